// ===== design/bt3_pkg.sv =====
// ----------------------------------------------------------------------------
// bt3_pkg
// Types and constants shared by the 3x3 local threshold block.
// ----------------------------------------------------------------------------
package bt3_pkg;

    localparam int PIX_W    = 8;
    localparam int FW_W     = 12;
    localparam int FH_W     = 12;
    localparam int FLOOR_W  = 8;
    localparam int APB_AW   = 4;
    localparam int APB_DW   = 32;

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [1:0]       t_reg_idx;

    // register map, index = paddr[3:2]
    localparam t_reg_idx REG_FRAME_WIDTH    = 2'd0;
    localparam t_reg_idx REG_FRAME_HEIGHT   = 2'd1;
    localparam t_reg_idx REG_CONTRAST_FLOOR = 2'd2;

    localparam logic [FW_W-1:0]    RST_FRAME_WIDTH    = 12'd640;
    localparam logic [FH_W-1:0]    RST_FRAME_HEIGHT   = 12'd480;
    localparam logic [FLOOR_W-1:0] RST_CONTRAST_FLOOR = 8'd1;

    localparam t_pix PIX_ON  = 8'd255;
    localparam t_pix PIX_OFF = 8'd0;

    // result queue
    localparam int RES_FIFO_DEPTH = 16;
    localparam int RES_FIFO_AW    = 4;
    localparam int RES_FIFO_CW    = 5;

    typedef struct packed {
        t_pix pixel_out;
        logic row_end;
        logic frame_end;
    } t_res_word;

    // window, indexed [column oldest..newest][row top,mid,bot]
    typedef t_pix [2:0][2:0] t_win;

    // per-item result control, carried down the pipeline
    typedef struct packed {
        logic res_a;     // centre in middle column
        logic res_b;     // centre in newest column (row end)
        logic left_a;
        logic left_b;
        logic top_ok;
        logic bot_ok;
        logic frame_end;
    } t_res_ctl;

endpackage

// ===== design/bt3_pix_if.sv =====
// ----------------------------------------------------------------------------
// bt3_pix_if
// Input pixel channel: valid/ready with pixel and pad flag.
// ----------------------------------------------------------------------------
interface bt3_pix_if;
    import bt3_pkg::*;

    logic valid;
    logic ready;
    t_pix pixel_in;
    logic is_pad;

    modport source (output valid, output pixel_in, output is_pad, input ready);
    modport sink   (input valid, input pixel_in, input is_pad, output ready);

endinterface

// ===== design/bt3_res_if.sv =====
// ----------------------------------------------------------------------------
// bt3_res_if
// Result channel: valid/ready with binarised pixel and row/frame markers.
// ----------------------------------------------------------------------------
interface bt3_res_if;
    import bt3_pkg::*;

    logic valid;
    logic ready;
    t_pix pixel_out;
    logic row_end;
    logic frame_end;

    modport source (output valid, output pixel_out, output row_end, output frame_end,
                    input ready);
    modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                    output ready);

endinterface

// ===== design/bt3_ram.sv =====
// ----------------------------------------------------------------------------
// bt3_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bt3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/bt3_res_fifo.sv =====
// ----------------------------------------------------------------------------
// bt3_res_fifo
// Result queue taking up to two words a cycle and giving one.
// ----------------------------------------------------------------------------
module bt3_res_fifo (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr0,
    input  bt3_pkg::t_res_word           i_word0,
    input  logic                         i_wr1,
    input  bt3_pkg::t_res_word           i_word1,
    bt3_res_if.source                    o_res,
    output logic [bt3_pkg::RES_FIFO_CW-1:0] o_count
);
    import bt3_pkg::*;

    t_res_word                r_mem [RES_FIFO_DEPTH];
    logic [RES_FIFO_AW-1:0]   r_rd_ptr;
    logic [RES_FIFO_AW-1:0]   r_wr_ptr;
    logic [RES_FIFO_CW-1:0]   r_count;
    logic                     pop;
    logic [RES_FIFO_AW-1:0]   wr_ptr_p1;
    logic [RES_FIFO_CW-1:0]   n_pushed;
    t_res_word                head;

    assign head      = r_mem[r_rd_ptr];
    assign pop       = o_res.valid && o_res.ready;
    assign wr_ptr_p1 = r_wr_ptr + RES_FIFO_AW'(1);
    assign n_pushed  = RES_FIFO_CW'(i_wr0) + RES_FIFO_CW'(i_wr1);

    always_ff @(posedge i_clk) begin
        if (i_wr0) begin
            r_mem[r_wr_ptr] <= i_word0;
        end
        if (i_wr1) begin
            r_mem[wr_ptr_p1] <= i_word1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + RES_FIFO_AW'(n_pushed);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + RES_FIFO_AW'(1);
            end
            r_count <= r_count + n_pushed - RES_FIFO_CW'(pop);
        end
    end

    assign o_res.valid     = (r_count != '0);
    assign o_res.pixel_out = head.pixel_out;
    assign o_res.row_end   = head.row_end;
    assign o_res.frame_end = head.frame_end;
    assign o_count         = r_count;

endmodule

// ===== design/bernsen_threshold_3x3.sv =====
// ----------------------------------------------------------------------------
// bernsen_threshold_3x3
// Streaming 3x3 local (midrange) threshold with two line stores.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        word
//  i_pix     in   valid/ready      pixel_in[7:0], is_pad
//  o_res     out  valid/ready      pixel_out[7:0], row_end, frame_end
//  apb       in   psel/penable     regs 0x0 width, 0x4 height, 0x8 floor
//
//  One pixel word is taken per clock while i_pix.ready is high. A result
//  passes line store read at the accepting edge, then window update,
//  min/max and threshold, then is pushed into the output queue, which offers
//  it on o_res. The line stores share one RAM whose single write port sets
//  the rate of one word a cycle.
//  Reset is synchronous and active low; line store contents stay undefined.
//  i_pix.ready drops only when the 16-word result queue, less the results
//  still in flight, could not take two more words.
// ----------------------------------------------------------------------------
module bernsen_threshold_3x3 #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bt3_pix_if.sink                     i_pix,
    bt3_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bt3_pkg::APB_AW-1:0]  paddr,
    input  logic [bt3_pkg::APB_DW-1:0]  pwdata,
    output logic [bt3_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import bt3_pkg::*;

    // column index width, and a width able to hold MAX_WIDTH and the register
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = ($clog2(MAX_WIDTH + 1) > FW_W) ? $clog2(MAX_WIDTH + 1) : FW_W;
    localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);
    localparam int LW = 2 * PIX_W;   // one line store entry: {row two up, row one up}

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [FW_W-1:0]    r_frame_width;
    logic [FH_W-1:0]    r_frame_height;
    logic [FLOOR_W-1:0] r_contrast_floor;
    logic               cfg_wr;
    t_reg_idx           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width    <= RST_FRAME_WIDTH;
            r_frame_height   <= RST_FRAME_HEIGHT;
            r_contrast_floor <= RST_CONTRAST_FLOOR;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_FRAME_WIDTH:    r_frame_width    <= pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT:   r_frame_height   <= pwdata[FH_W-1:0];
                REG_CONTRAST_FLOOR: r_contrast_floor <= pwdata[FLOOR_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_FRAME_WIDTH:    prdata = APB_DW'(r_frame_width);
            REG_FRAME_HEIGHT:   prdata = APB_DW'(r_frame_height);
            REG_CONTRAST_FLOOR: prdata = APB_DW'(r_contrast_floor);
            default:            prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 0: raster position, accept, line store read
    // ------------------------------------------------------------------
    logic [CW-1:0]   r_col;
    logic [FH_W-1:0] r_row;
    logic [WW-1:0]   fw_ext;
    logic [WW-1:0]   eff_w;
    logic [CW-1:0]   last_idx;
    logic [FH_W-1:0] eff_h;
    logic [CW-1:0]   col;
    logic            flush;
    logic            last_col;
    logic            accept;
    logic            take;
    t_res_ctl        ctl0;

    assign fw_ext   = WW'(r_frame_width);
    assign eff_w    = (fw_ext == '0) ? WW'(1) : ((fw_ext > MAXW) ? MAXW : fw_ext);
    assign last_idx = CW'(eff_w - WW'(1));
    assign eff_h    = (r_frame_height == '0) ? FH_W'(1) : r_frame_height;
    assign flush    = (r_row >= eff_h);
    // clamp a column left past the row end by a width change
    assign col      = (r_col > last_idx) ? last_idx : r_col;
    assign last_col = (col == last_idx);
    assign accept   = i_pix.valid && i_pix.ready;
    // drop a pad word that arrives inside the frame
    assign take     = accept && !(i_pix.is_pad && !flush);

    always_comb begin
        ctl0.res_a     = (r_row != '0) && (col != '0);
        ctl0.res_b     = (r_row != '0) && last_col;
        ctl0.left_a    = (col > CW'(1));
        ctl0.left_b    = (col != '0);
        ctl0.top_ok    = (r_row > FH_W'(1));
        ctl0.bot_ok    = !flush;
        ctl0.frame_end = flush;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (take) begin
            if (last_col) begin
                r_col <= '0;
                r_row <= flush ? '0 : r_row + FH_W'(1);
            end else begin
                r_col <= col + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: line store data back, window shift, write back
    // ------------------------------------------------------------------
    logic            r_s1_valid;
    logic [CW-1:0]   r_s1_col;
    t_pix            r_s1_pix;
    t_res_ctl        r_s1_ctl;
    logic            r_s1_fwd;
    logic [LW-1:0]   r_fwd_data;
    logic [LW-1:0]   ram_rdata;
    logic [LW-1:0]   s1_line;
    logic [LW-1:0]   s1_wdata;
    t_pix            s1_top;
    t_pix            s1_mid;
    t_win            r_win;
    t_win            n_win;

    // one entry holds both line stores: upper byte row two up, lower row one up
    bt3_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_s1_valid),
        .i_waddr (r_s1_col),
        .i_wdata (s1_wdata),
        .i_re    (take),
        .i_raddr (col),
        .o_rdata (ram_rdata)
    );

    // a one-column frame reads the entry stage 1 is writing in the same cycle
    assign s1_line  = r_s1_fwd ? r_fwd_data : ram_rdata;
    assign s1_top   = s1_line[LW-1:PIX_W];
    assign s1_mid   = s1_line[PIX_W-1:0];
    assign s1_wdata = {s1_mid, r_s1_pix};

    always_comb begin
        n_win       = r_win;
        n_win[0]    = r_win[1];
        n_win[1]    = r_win[2];
        n_win[2][0] = s1_top;
        n_win[2][1] = s1_mid;
        n_win[2][2] = r_s1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_s1_col   <= col;
            r_s1_pix   <= flush ? PIX_OFF : i_pix.pixel_in;
            r_s1_ctl   <= ctl0;
            r_s1_fwd   <= r_s1_valid && (r_s1_col == col);
            r_fwd_data <= s1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_s1_valid) begin
            r_win <= n_win;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: masked min/max over the window for both candidate centres
    // ------------------------------------------------------------------
    function automatic logic [LW-1:0] f_minmax(t_win w, logic [2:0] cm, logic [2:0] rm);
        t_pix mn;
        t_pix mx;
        mn = PIX_ON;
        mx = PIX_OFF;
        for (int c = 0; c < 3; c++) begin
            for (int r = 0; r < 3; r++) begin
                if (cm[c] && rm[r]) begin
                    if (w[c][r] < mn) mn = w[c][r];
                    if (w[c][r] > mx) mx = w[c][r];
                end
            end
        end
        return {mn, mx};
    endfunction

    logic            r_s2_valid;
    t_res_ctl        r_s2_ctl;
    logic [2:0]      s2_rows;
    logic [LW-1:0]   s2_mm_a;
    logic [LW-1:0]   s2_mm_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid && (r_s1_ctl.res_a || r_s1_ctl.res_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            r_s2_ctl <= r_s1_ctl;
        end
    end

    assign s2_rows = {r_s2_ctl.bot_ok, 1'b1, r_s2_ctl.top_ok};
    assign s2_mm_a = f_minmax(r_win, {1'b1, 1'b1, r_s2_ctl.left_a}, s2_rows);
    assign s2_mm_b = f_minmax(r_win, {1'b1, r_s2_ctl.left_b, 1'b0}, s2_rows);

    // ------------------------------------------------------------------
    // Stage 3: midrange and threshold, push into the result queue
    // ------------------------------------------------------------------
    logic            r_s3_valid;
    t_res_ctl        r_s3_ctl;
    logic [LW-1:0]   r_s3_mm_a;
    logic [LW-1:0]   r_s3_mm_b;
    t_pix            r_s3_ctr_a;
    t_pix            r_s3_ctr_b;
    t_pix            mid_a;
    t_pix            mid_b;
    t_res_word       word_a;
    t_res_word       word_b;
    logic            wr0;
    logic            wr1;
    t_res_word       word0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_s3_ctl   <= r_s2_ctl;
            r_s3_mm_a  <= s2_mm_a;
            r_s3_mm_b  <= s2_mm_b;
            r_s3_ctr_a <= r_win[1][1];
            r_s3_ctr_b <= r_win[2][1];
        end
    end

    assign mid_a = PIX_W'(({1'b0, r_s3_mm_a[LW-1:PIX_W]} + {1'b0, r_s3_mm_a[PIX_W-1:0]}) >> 1);
    assign mid_b = PIX_W'(({1'b0, r_s3_mm_b[LW-1:PIX_W]} + {1'b0, r_s3_mm_b[PIX_W-1:0]}) >> 1);

    always_comb begin
        word_a.pixel_out = (mid_a < r_contrast_floor) ? PIX_OFF :
                           ((r_s3_ctr_a > mid_a) ? PIX_ON : PIX_OFF);
        word_a.row_end   = 1'b0;
        word_a.frame_end = 1'b0;
        word_b.pixel_out = (mid_b < r_contrast_floor) ? PIX_OFF :
                           ((r_s3_ctr_b > mid_b) ? PIX_ON : PIX_OFF);
        word_b.row_end   = 1'b1;
        word_b.frame_end = r_s3_ctl.frame_end;
    end

    // middle-column result goes first, the row-end one after it
    assign wr0   = r_s3_valid && (r_s3_ctl.res_a || r_s3_ctl.res_b);
    assign wr1   = r_s3_valid && r_s3_ctl.res_a && r_s3_ctl.res_b;
    assign word0 = r_s3_ctl.res_a ? word_a : word_b;

    logic [RES_FIFO_CW-1:0] fifo_count;

    bt3_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr0   (wr0),
        .i_word0 (word0),
        .i_wr1   (wr1),
        .i_word1 (word_b),
        .o_res   (o_res),
        .o_count (fifo_count)
    );

    // ------------------------------------------------------------------
    // Flow control: reserve queue room for every result still in flight
    // ------------------------------------------------------------------
    localparam int PW = RES_FIFO_CW + 1;

    logic [PW-1:0] pend;
    logic [PW-1:0] need;

    assign pend = (r_s1_valid ? PW'(r_s1_ctl.res_a) + PW'(r_s1_ctl.res_b) : PW'(0))
                + (r_s2_valid ? PW'(r_s2_ctl.res_a) + PW'(r_s2_ctl.res_b) : PW'(0))
                + (r_s3_valid ? PW'(r_s3_ctl.res_a) + PW'(r_s3_ctl.res_b) : PW'(0));
    assign need = PW'(fifo_count) + pend + PW'(2);

    assign i_pix.ready = (need <= PW'(RES_FIFO_DEPTH));

endmodule

// ===== tb/sv/tb_bernsen_threshold_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bernsen_threshold_3x3
// Self-checking bench for the streaming 3x3 local midrange threshold. Frames
// of grey pixel words are pushed through the input channel with random gaps.
// A scoreboard keeps its own copy of the line stores, window and counters and
// predicts every binarised pixel, row end and frame end. Results are checked
// in order as the receiver takes them, under random back-pressure and one
// long hold-off that fills the block.
// ----------------------------------------------------------------------------
module tb_bernsen_threshold_3x3;
    import bt3_pkg::*;

    localparam int          MAX_W          = 2048;
    localparam int unsigned CYCLE_LIMIT    = 1000000;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    // four pipeline stages plus the output queue, with room to spare
    localparam int unsigned SETTLE_CYCLES  = 16;
    localparam int unsigned RANDOM_ITEMS   = 560;

    // pixel content of one frame
    typedef enum int {
        STY_NOISE,
        STY_FLAT_LOW,
        STY_EXTREME,
        STY_CONST,
        STY_RAMP
    } t_pix_style;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts the binarised stream and checks what comes out
    // ------------------------------------------------------------------------
    class t_threshold_scoreboard;
        logic [FW_W-1:0]    width_reg;
        logic [FH_W-1:0]    height_reg;
        logic [FLOOR_W-1:0] floor_reg;
        t_pix               row_above2 [MAX_W];
        t_pix               row_above1 [MAX_W];
        t_pix               win [3][3];   // [column oldest..newest][row top,mid,bot]
        int unsigned        col_pos;
        int unsigned        row_pos;
        t_res_word          expected_pixels [$];
        int unsigned        taken;
        int unsigned        ignored;
        int unsigned        checked;
        int unsigned        errors;

        function new();
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            floor_reg  = RST_CONTRAST_FLOOR;
            for (int i = 0; i < MAX_W; i++) begin
                row_above2[i] = '0;
                row_above1[i] = '0;
            end
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win[k][j] = '0;
                end
            end
            col_pos = 0;
            row_pos = 0;
            taken   = 0;
            ignored = 0;
            checked = 0;
            errors  = 0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [APB_DW-1:0] val);
            if (idx == REG_FRAME_WIDTH) begin
                width_reg = val[FW_W-1:0];
            end else if (idx == REG_FRAME_HEIGHT) begin
                height_reg = val[FH_W-1:0];
            end else if (idx == REG_CONTRAST_FLOOR) begin
                floor_reg = val[FLOOR_W-1:0];
            end
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        // Midrange threshold of the centre in window column k; the flags say
        // which neighbours lie inside the frame.
        function t_pix binarise(int k, bit left, bit right, bit top, bit bot);
            int unsigned mn;
            int unsigned mx;
            int unsigned mid;
            mn = 255;
            mx = 0;
            for (int col = k - 1; col <= k + 1; col++) begin
                if (col < 0 || col > 2) continue;
                if (col == k - 1 && !left) continue;
                if (col == k + 1 && !right) continue;
                for (int row = 0; row < 3; row++) begin
                    if (row == 0 && !top) continue;
                    if (row == 2 && !bot) continue;
                    if (win[col][row] < mn) mn = win[col][row];
                    if (win[col][row] > mx) mx = win[col][row];
                end
            end
            mid = (mn + mx) >> 1;
            if (mid < floor_reg) return PIX_OFF;
            return (win[k][1] > mid) ? PIX_ON : PIX_OFF;
        endfunction

        function void note_input(t_pix pix, bit pad);
            int unsigned w;
            int unsigned h;
            int unsigned r;
            int unsigned c;
            bit          flush;
            bit          last_col;
            bit          top_ok;
            bit          bot_ok;
            t_pix        p;
            t_pix        up2;
            t_pix        up1;
            t_res_word   e;
            w = width_reg;
            if (w < 1) w = 1;
            if (w > MAX_W) w = MAX_W;
            h = (height_reg == 0) ? 1 : height_reg;
            r = row_pos;
            c = col_pos;
            flush = (r >= h);
            // a pad inside the frame leaves everything untouched
            if (!flush && pad) begin
                ignored++;
                return;
            end
            taken++;
            if (c > w - 1) c = w - 1;
            last_col = (c == w - 1);

            // anything in the flush row enters as zero
            p   = flush ? PIX_OFF : pix;
            up2 = row_above2[c];
            up1 = row_above1[c];
            for (int k = 0; k < 2; k++) begin
                for (int j = 0; j < 3; j++) begin
                    win[k][j] = win[k + 1][j];
                end
            end
            win[2][0] = up2;
            win[2][1] = up1;
            win[2][2] = p;
            row_above2[c] = up1;
            row_above1[c] = p;

            if (r >= 1) begin
                top_ok = (r >= 2);
                bot_ok = (r < h);
                if (c >= 1) begin
                    e.pixel_out = binarise(1, c >= 2, 1'b1, top_ok, bot_ok);
                    e.row_end   = 1'b0;
                    e.frame_end = 1'b0;
                    expected_pixels.push_back(e);
                end
                // last pixel of the row above comes out with its neighbour
                if (last_col) begin
                    e.pixel_out = binarise(2, c >= 1, 1'b0, top_ok, bot_ok);
                    e.row_end   = 1'b1;
                    e.frame_end = flush;
                    expected_pixels.push_back(e);
                end
            end

            if (last_col) begin
                col_pos = 0;
                row_pos = flush ? 0 : ((r + 1) & 32'hFFF);
            end else begin
                col_pos = c + 1;
            end
        endfunction

        function void check_result(t_res_word got);
            t_res_word e;
            if (expected_pixels.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result word: pix %0h row_end %0h frame_end %0h",
                             got.pixel_out, got.row_end, got.frame_end);
                end
                return;
            end
            e = expected_pixels.pop_front();
            checked++;
            if (got.pixel_out !== e.pixel_out || got.row_end !== e.row_end ||
                got.frame_end !== e.frame_end) begin
                errors++;
                if (errors <= 10) begin
                    $display("result %0d wrong: expected pix %0d row_end %0b frame_end %0b,",
                             checked, e.pixel_out, e.row_end, e.frame_end);
                    $display("    got pix %0h row_end %0h frame_end %0h",
                             got.pixel_out, got.row_end, got.frame_end);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block and its ports
    // ------------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    bt3_pix_if pix_ch ();
    bt3_res_if res_ch ();

    bernsen_threshold_3x3 #(
        .MAX_WIDTH (MAX_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_ch),
        .o_res   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_threshold_scoreboard sb = new();

    int unsigned tx_idle_pct;    // chance of a gap before each input word
    int unsigned rx_idle_pct;    // chance of the receiver starting a stall
    int unsigned pad_pct;        // chance of a stray pad inside the frame
    int unsigned frames;
    int unsigned cycles;
    logic        pressure_req;   // asks the hold-off process to start
    logic        hold_rx;        // receiver held off while high

    // ------------------------------------------------------------------------
    // Clock and watchdog
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("timed out after %0d cycles with %0d results outstanding",
                 cycles, sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: check every taken word, stall in random bursts
    // ------------------------------------------------------------------------
    initial begin
        int unsigned gap;
        t_res_word   got;
        gap = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got = t_res_word'({res_ch.pixel_out, res_ch.row_end, res_ch.frame_end});
                sb.check_result(got);
            end
            if (hold_rx) begin
                res_ch.ready <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                res_ch.ready <= 1'b0;
            end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
                gap = $urandom_range(7, 1) - 1;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    // Long hold-off on the result side, counted here so that the sender keeps
    // offering words until the block has to stall its input.
    initial begin
        hold_rx = 1'b0;
        do @(posedge i_clk); while (!pressure_req);
        hold_rx <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // Setup cycle, access cycle, then an idle cycle with psel low so that
    // back-to-back writes never raise and drop psel in the same step.
    task automatic apb_write(t_reg_idx idx, logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.write_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_geometry(int unsigned w, int unsigned h, int unsigned fl);
        apb_write(REG_FRAME_WIDTH, w);
        apb_write(REG_FRAME_HEIGHT, h);
        apb_write(REG_CONTRAST_FLOOR, fl);
    endtask

    // Offer one word, maybe after a gap, and hold it until it is taken.
    task automatic send_word(t_pix pix, bit pad);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge i_clk);
        end
        pix_ch.valid    <= 1'b1;
        pix_ch.pixel_in <= pix;
        pix_ch.is_pad   <= pad;
        do @(posedge i_clk); while (!pix_ch.ready);
        sb.note_input(pix, pad);
    endtask

    // Wait until every predicted word has arrived, then let the pipeline
    // settle before the registers may be touched again.
    task automatic drain();
        do @(posedge i_clk); while (sb.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic finish_frame();
        pix_ch.valid <= 1'b0;
        frames++;
        drain();
    endtask

    function automatic t_pix make_pixel(t_pix_style sty, int unsigned r, int unsigned c,
                                        t_pix base);
        case (sty)
            STY_NOISE:    return t_pix'($urandom_range(255));
            STY_FLAT_LOW: return t_pix'(base + $urandom_range(3));
            STY_EXTREME:  return $urandom_range(1) ? PIX_ON : PIX_OFF;
            STY_CONST:    return base;
            default:      return t_pix'((r * 37 + c * 23 + $urandom_range(7)) & 255);
        endcase
    endfunction

    // One whole frame: geometry, pixels with stray pads, then the flush row,
    // part of it sent as ordinary pixels whose value must be ignored.
    task automatic run_frame(int unsigned w, int unsigned h, int unsigned fl,
                             t_pix_style sty);
        int unsigned we;
        int unsigned he;
        t_pix        base;
        set_geometry(w, h, fl);
        we = (w & 12'hFFF);
        if (we < 1) we = 1;
        if (we > MAX_W) we = MAX_W;
        he = ((h & 12'hFFF) == 0) ? 1 : (h & 12'hFFF);
        base = t_pix'($urandom_range(252));
        for (int unsigned r = 0; r < he; r++) begin
            for (int unsigned c = 0; c < we; c++) begin
                if (pad_pct != 0 && $urandom_range(99) < pad_pct) begin
                    send_word(t_pix'($urandom_range(255)), 1'b1);
                end
                send_word(make_pixel(sty, r, c, base), 1'b0);
            end
        end
        for (int unsigned c = 0; c < we; c++) begin
            send_word(t_pix'($urandom_range(255)), $urandom_range(99) >= 25);
        end
        finish_frame();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned rand_base;
        int unsigned w;
        int unsigned h;
        int unsigned fl;
        t_pix        dir_a [9];

        i_rst_n         = 1'b0;
        pix_ch.valid    = 1'b0;
        pix_ch.pixel_in = '0;
        pix_ch.is_pad   = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        pressure_req    = 1'b0;
        rx_idle_pct     = 0;
        tx_idle_pct     = 0;
        pad_pct         = 0;
        frames          = 0;
        dir_a = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd128};

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: 3x3 checkerboard of extremes, the last pixel mid-grey, floor zero,
        // a stray pad mid-frame and a pixel inside the flush row.
        tx_idle_pct  = 20;
        rx_idle_pct <= 20;
        set_geometry(3, 3, 0);
        for (int i = 0; i < 9; i++) begin
            if (i == 4) send_word(8'hA5, 1'b1);
            send_word(dir_a[i], 1'b0);
        end
        send_word(PIX_OFF, 1'b1);
        send_word(8'd77, 1'b0);
        send_word(PIX_ON, 1'b1);
        finish_frame();

        // single pixel frames: top floor, then width and height of zero; then a 2x2 frame
        run_frame(1, 1, 255, STY_NOISE);
        run_frame(0, 0, 128, STY_CONST);
        run_frame(2, 2, 1, STY_EXTREME);

        // A wide short frame and a one-column tall frame.
        pad_pct = 2;
        run_frame(48, 2, 0, STY_NOISE);
        run_frame(1, 96, 1, STY_RAMP);

        // Back-pressure: hold the receiver off while words keep coming.
        tx_idle_pct  = 0;
        rx_idle_pct <= 0;
        pad_pct      = 0;
        pressure_req <= 1'b1;
        run_frame(16, 8, 1, STY_NOISE);

        // Random frames, mostly small, with changing idle patterns.
        rand_base = sb.taken;
        while (sb.taken - rand_base < RANDOM_ITEMS) begin
            case ($urandom_range(3))
                0:       tx_idle_pct = 0;
                1:       tx_idle_pct = 10;
                2:       tx_idle_pct = 30;
                default: tx_idle_pct = 50;
            endcase
            case ($urandom_range(3))
                0:       rx_idle_pct <= 0;
                1:       rx_idle_pct <= 10;
                2:       rx_idle_pct <= 30;
                default: rx_idle_pct <= 50;
            endcase
            pad_pct = $urandom_range(10);
            w = $urandom_range(12, 1);
            h = $urandom_range(8, 1);
            case ($urandom_range(4))
                0:       fl = 0;
                1:       fl = 255;
                default: fl = $urandom_range(255);
            endcase
            run_frame(w, h, fl, t_pix_style'($urandom_range(4)));
        end

        // Closing stretch at full rate on both sides.
        tx_idle_pct  = 0;
        rx_idle_pct <= 0;
        pad_pct      = 0;
        run_frame(7, 5, 1, STY_NOISE);
        run_frame(12, 4, $urandom_range(255), STY_RAMP);

        drain();
        $display("ran %0d frames: %0d pixel words taken, %0d stray pads dropped",
                 frames, sb.taken, sb.ignored);
        $display("checked %0d result words, %0d failures, widths 1 to 48, long stall",
                 sb.checked, sb.errors);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
